// File: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types and constants for the base64url stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_DANGLING = 2'd2
  } status_t;

  // one group request from front to back: one to three result items
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] count;   // number of result items, 1..3
    status_t    status;
    logic       last;    // run_last of the final item of the group
  } group_rec_t;

endpackage

// File: design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// maps characters to sextets, gathers groups and emits group requests
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          char_code,
  input  logic                end_of_string,
  output logic                rec_valid,
  output b64d_pkg::group_rec_t rec
);
  import b64d_pkg::*;

  logic [17:0] acc;
  logic [1:0]  cnt;
  logic        discarding;

  logic [17:0] acc_next;
  logic [1:0]  cnt_next;
  logic        discarding_next;

  logic        sx_ok;
  logic [5:0]  sx;
  logic [23:0] wide;
  logic [17:0] grown;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2d) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5f) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  assign {sx_ok, sx} = sextet_of(char_code);
  assign wide  = {acc, sx};
  assign grown = wide[17:0];

  always_comb begin
    acc_next        = acc;
    cnt_next        = cnt;
    discarding_next = discarding;
    rec_valid       = 1'b0;
    rec             = '0;
    rec.status      = ST_DATA;
    if (discarding) begin
      if (end_of_string) begin
        discarding_next = 1'b0;
      end
    end else if (!sx_ok) begin
      acc_next        = '0;
      cnt_next        = '0;
      discarding_next = !end_of_string;
      rec_valid       = 1'b1;
      rec.count       = 2'd1;
      rec.status      = ST_BAD_CHAR;
      rec.last        = 1'b1;
    end else if (cnt == 2'd3) begin
      acc_next  = '0;
      cnt_next  = '0;
      rec_valid = 1'b1;
      rec.byte0 = wide[23:16];
      rec.byte1 = wide[15:8];
      rec.byte2 = wide[7:0];
      rec.count = 2'd3;
      rec.last  = end_of_string;
    end else if (!end_of_string) begin
      acc_next = grown;
      cnt_next = cnt + 2'd1;
    end else begin
      // final short group
      acc_next  = '0;
      cnt_next  = '0;
      rec_valid = 1'b1;
      rec.last  = 1'b1;
      unique case (cnt)
        2'd0: begin
          rec.count  = 2'd1;
          rec.status = ST_DANGLING;
        end
        2'd1: begin
          rec.count = 2'd1;
          rec.byte0 = grown[11:4];
        end
        default: begin
          rec.count = 2'd2;
          rec.byte0 = grown[17:10];
          rec.byte1 = grown[9:2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      discarding <= 1'b0;
    end else if (take) begin
      acc        <= acc_next;
      cnt        <= cnt_next;
      discarding <= discarding_next;
    end
  end

endmodule

// File: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// short queue of group requests between front and back
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  b64d_pkg::group_rec_t wr_data,
  input  logic                 rd_en,
  output b64d_pkg::group_rec_t rd_data,
  output logic                 full,
  output logic                 not_empty
);
  import b64d_pkg::*;

  group_rec_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  logic do_wr;
  logic do_rd;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// splits group requests into single result items on the output register
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  b64d_pkg::group_rec_t q_data,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic [1:0]           status,
  output logic                 run_last
);
  import b64d_pkg::*;

  group_rec_t cur;
  logic       cur_valid;
  logic [1:0] idx;

  logic done_item;
  logic group_end;

  assign empty     = !cur_valid;
  assign done_item = cur_valid && pop;
  assign group_end = (idx == cur.count - 2'd1);
  // load a new group when idle or when the last item of this one leaves
  assign q_rd      = q_not_empty && (!cur_valid || (done_item && group_end));

  always_comb begin
    unique case (idx)
      2'd0:    out_byte = cur.byte0;
      2'd1:    out_byte = cur.byte1;
      default: out_byte = cur.byte2;
    endcase
  end

  assign status   = cur.status;
  assign run_last = cur.last && group_end;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done_item) begin
      if (group_end) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: design/base64url_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// unpadded base64url decoder, one character in, decoded bytes out
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      char_code[7:0], end_of_string
//  result    empty / pop      out_byte[7:0], status[1:0], run_last
//
//  one character is taken per cycle while full is low; full rises only when
//  the four-entry group queue between front and back is full
//  a group request leaves the back end as one to three result items, one per
//  cycle while pop is high; a request is registered in the queue, then in cur
//  rst is synchronous and clears the group, the discard flag and the queue
//  a stalled result side fills the queue and then holds off input via full
// ----------------------------------------------------------------------------
module base64url_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       run_last
);
  import b64d_pkg::*;

  logic       take;
  logic       rec_valid;
  group_rec_t rec;
  group_rec_t q_data;
  logic       q_rd;
  logic       q_not_empty;

  assign take = push && !full;

  b64d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .rec_valid     (rec_valid),
    .rec           (rec)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (take && rec_valid),
    .wr_data   (rec),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .full      (full),
    .not_empty (q_not_empty)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .status      (status),
    .run_last    (run_last)
  );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks base64url_stream_decoder against a local decoder model: directed
// alphabet, bad-character and end-of-string cases, then random strings with random gaps on
// both handshakes and a stretch with no gaps at all
// ----------------------------------------------------------------------------
module testbench;
  import b64d_pkg::*;

  localparam logic [7:0] CH_DASH       = "-";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam int         IDLE_PCT      = 11;
  localparam int         DRAIN_CYCLES  = 16;

  typedef struct {
    logic [7:0] data;
    status_t    code;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code = 8'd0;
  logic       end_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       run_last;

  // model state
  logic [17:0] sextets = '0;
  logic [1:0]  sextet_count = '0;
  logic        dropping = 1'b0;

  decoded_t decoded_q[$];
  int       mismatch_count = 0;
  bit       no_gaps = 1'b0;

  base64url_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .end_of_string(end_of_string),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .status       (status),
    .run_last     (run_last)
  );

  always #10 clk = ~clk;

  function automatic int sextet_of_char(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return 26 + int'(c - "a");
    if (c >= "0" && c <= "9") return 52 + int'(c - "0");
    if (c == CH_DASH) return 62;
    if (c == CH_UNDERSCORE) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] char_of_sextet(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return CH_DASH;
    return CH_UNDERSCORE;
  endfunction

  function automatic void add_decoded(logic [7:0] data, status_t code, logic last);
    decoded_t d;
    d.data = data;
    d.code = code;
    d.last = last;
    decoded_q.push_back(d);
  endfunction

  function automatic void decode_char(logic [7:0] c, logic eos);
    int          v;
    logic [23:0] acc;
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return;
    end
    v = sextet_of_char(c);
    if (v < 0) begin
      sextets = '0;
      sextet_count = '0;
      dropping = !eos;
      add_decoded(8'd0, ST_BAD_CHAR, 1'b1);
      return;
    end
    acc = {sextets, 6'(v)};
    if (sextet_count == 2'd3) begin
      sextets = '0;
      sextet_count = '0;
      add_decoded(acc[23:16], ST_DATA, 1'b0);
      add_decoded(acc[15:8], ST_DATA, 1'b0);
      add_decoded(acc[7:0], ST_DATA, eos);
      return;
    end
    sextets = acc[17:0];
    sextet_count = sextet_count + 2'd1;
    if (!eos) return;
    // short final group, leftover low bits are not checked
    case (sextet_count)
      2'd1: add_decoded(8'd0, ST_DANGLING, 1'b1);
      2'd2: add_decoded(sextets[11:4], ST_DATA, 1'b1);
      default: begin
        add_decoded(sextets[17:10], ST_DATA, 1'b0);
        add_decoded(sextets[9:2], ST_DATA, 1'b1);
      end
    endcase
    sextets = '0;
    sextet_count = '0;
  endfunction

  // push stays high after acceptance, it is lowered only on a gap
  task automatic send_char(input logic [7:0] c, input logic eos);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      char_code <= 8'($urandom);
      end_of_string <= 1'($urandom);
      @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_char(c, eos);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // mostly well-formed strings, some with one bad character, some pure noise
  task automatic send_random_string(output int sent);
    int         len;
    int         kind;
    int         bad_pos;
    logic [7:0] c;
    len = $urandom_range(1, 9);
    kind = $urandom_range(0, 99);
    bad_pos = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (kind >= 90 || (kind >= 75 && i == bad_pos)) c = 8'($urandom);
      else c = char_of_sextet($urandom_range(0, 63));
      send_char(c, i == len - 1);
    end
    sent = len;
  endtask

  task automatic test_alphabet_edges();
    send_text("AZaz");
    send_text("09-_");
    send_text("__");
    send_text("___");
    send_text("A");
  endtask

  task automatic test_bad_chars();
    // bad character as the only character, then mid-string with dropped tail
    send_char(8'h00, 1'b1);
    send_char("A", 1'b0);
    send_char("B", 1'b0);
    send_char(8'hff, 1'b0);
    send_char("C", 1'b0);
    send_char("D", 1'b1);
    // bad character on the end of string ends the string, no dropping
    send_char("A", 1'b0);
    send_char(8'h80, 1'b1);
    send_text("QUJD");
  endtask

  task automatic test_random_strings(input int target);
    int total;
    int n;
    total = 0;
    while (total < target) begin
      send_random_string(n);
      total += n;
    end
  endtask

  task automatic test_back_to_back(input int target);
    int total;
    int n;
    total = 0;
    no_gaps = 1'b1;
    while (total < target) begin
      send_random_string(n);
      total += n;
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    decoded_t d;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h status %0d run_last %0b",
                 out_byte, status, run_last);
          mismatch_count++;
        end else begin
          d = decoded_q.pop_front();
          if (out_byte !== d.data) begin
            $error("out_byte: expected %0h, actual %0h", d.data, out_byte);
            mismatch_count++;
          end
          if (status !== d.code) begin
            $error("status: expected %0d, actual %0d", d.code, status);
            mismatch_count++;
          end
          if (run_last !== d.last) begin
            $error("run_last: expected %0b, actual %0b", d.last, run_last);
            mismatch_count++;
          end
        end
      end
      pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alphabet_edges();
    test_bad_chars();
    test_random_strings(250);
    test_back_to_back(60);
    test_random_strings(120);
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
